// ===== rtl/sle_pkg.sv =====
// Shared types and constants for the sorted list engine.
package sle_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 8;
    localparam int DATA_W = 32;
    localparam int TYPE_W = 2;
    localparam int STAT_W = 2;
    localparam int FILL_W = 5;

    typedef enum logic [TYPE_W-1:0] {
        REQ_INSERT     = 2'd0,
        REQ_REMOVE_ID  = 2'd1,
        REQ_REMOVE_POS = 2'd2,
        REQ_READ       = 2'd3
    } t_req_type;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ACT_HOLD      = 2'd0,
        ACT_LOAD      = 2'd1,
        ACT_FROM_PREV = 2'd2,
        ACT_FROM_NEXT = 2'd3
    } t_cell_act;

    typedef struct packed {
        logic lt;
        logic eq;
    } t_cell_flags;

endpackage

// ===== rtl/sle_if.sv =====
// Request and response channel interfaces of the sorted list engine.
interface sle_req_if import sle_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [TYPE_W-1:0]        req_type;
    logic signed [DATA_W-1:0] entry_id;
    logic signed [DATA_W-1:0] entry_key;
    logic [POS_W-1:0]         position;

    modport source (output valid, req_type, entry_id, entry_key, position, input ready);
    modport sink   (input valid, req_type, entry_id, entry_key, position, output ready);
endinterface

interface sle_rsp_if import sle_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [FILL_W-1:0]        fill_count;
    logic signed [DATA_W-1:0] found_id;
    logic signed [DATA_W-1:0] found_key;

    modport source (output valid, status, fill_count, found_id, found_key, input ready);
    modport sink   (input valid, status, fill_count, found_id, found_key, output ready);
endinterface

// ===== rtl/sorted_list_engine.sv =====
// Sorted list engine top level: a row of compare-and-shift cells with a two-state sequencer.
// Each cell registers its compare flags when a request is accepted in S_IDLE; in S_EXEC the
// cells shift and the response is registered, and a stalled response holds S_EXEC until the
// output frees up. A new request is taken only once the sequencer is back in S_IDLE.
// Reset (synchronous, active low) empties the list and clears the response valid at once;
// no clearing pass is needed because only slots below the fill count are ever read.
module sorted_list_engine import sle_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sle_req_if.sink   i_req,
    sle_rsp_if.source o_rsp
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_count;
    t_req_type                r_type;
    logic signed [DATA_W-1:0] r_id;
    logic signed [DATA_W-1:0] r_key;
    logic [POS_W-1:0]         r_pos;
    logic                     r_out_valid;
    t_status                  r_status;
    logic signed [DATA_W-1:0] r_found_id;
    logic signed [DATA_W-1:0] r_found_key;

    logic signed [DATA_W-1:0] cell_id  [DEPTH];
    logic signed [DATA_W-1:0] cell_key [DEPTH];
    t_cell_flags              cell_flags [DEPTH];
    t_cell_act                cell_act [DEPTH];

    logic [DEPTH-1:0]         occ;
    logic [DEPTH-1:0]         lt_vec;
    logic [DEPTH-1:0]         eq_vec;
    logic [DEPTH-1:0]         hit_before;
    logic [DEPTH-1:0]         sel;
    logic [DEPTH-1:0]         past_pos;
    logic [DEPTH-1:0]         below;
    logic                     accept;
    logic                     can_out;
    logic                     do_exec;
    logic                     full;
    logic                     id_hit;
    logic                     pos_hit;
    logic                     found;
    t_status                  n_status;
    logic [CNT_W-1:0]         n_count;
    logic signed [DATA_W-1:0] n_found_id;
    logic signed [DATA_W-1:0] n_found_key;

    assign accept  = i_req.valid && i_req.ready;
    assign can_out = !r_out_valid || o_rsp.ready;
    assign do_exec = (r_state == S_EXEC) && can_out;
    assign full    = (r_count == CNT_W'(DEPTH));
    assign id_hit  = |eq_vec;
    assign pos_hit = ({1'b0, r_pos} < (POS_W + 1)'(r_count));

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [DATA_W-1:0] prev_id;
            logic signed [DATA_W-1:0] prev_key;
            logic signed [DATA_W-1:0] next_id;
            logic signed [DATA_W-1:0] next_key;

            if (g == 0) begin : g_head
                assign prev_id  = r_id;
                assign prev_key = r_key;
            end else begin : g_mid
                assign prev_id  = cell_id[g-1];
                assign prev_key = cell_key[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign next_id  = cell_id[g];
                assign next_key = cell_key[g];
            end else begin : g_body
                assign next_id  = cell_id[g+1];
                assign next_key = cell_key[g+1];
            end

            assign occ[g]    = (CNT_W'(g) < r_count);
            assign lt_vec[g] = cell_flags[g].lt;
            assign eq_vec[g] = cell_flags[g].eq;

            sle_cell u_cell (
                .i_clk      (i_clk),
                .i_cap      (accept),
                .i_occ      (occ[g]),
                .i_cmp_id   (i_req.entry_id),
                .i_cmp_key  (i_req.entry_key),
                .i_act      (cell_act[g]),
                .i_new_id   (r_id),
                .i_new_key  (r_key),
                .i_prev_id  (prev_id),
                .i_prev_key (prev_key),
                .i_next_id  (next_id),
                .i_next_key (next_key),
                .o_id       (cell_id[g]),
                .o_key      (cell_key[g]),
                .o_flags    (cell_flags[g])
            );
        end
    endgenerate

    // Per-slot decisions; each slot looks only at its own flags, its left neighbor,
    // and whether an earlier slot already matched the id.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            below         = (DEPTH'(1) << i) - DEPTH'(1);
            hit_before[i] = |(eq_vec & below);
            past_pos[i]   = ((POS_W + 1)'(i) >= {1'b0, r_pos});
            if (r_type == REQ_REMOVE_ID) begin
                sel[i] = eq_vec[i] && !hit_before[i];
            end else begin
                sel[i] = ((POS_W + 1)'(i) == {1'b0, r_pos});
            end
        end

        found = ((r_type == REQ_REMOVE_ID) && id_hit) ||
                (((r_type == REQ_REMOVE_POS) || (r_type == REQ_READ)) && pos_hit);

        n_found_id  = '0;
        n_found_key = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (found && sel[i]) begin
                n_found_id  = n_found_id | cell_id[i];
                n_found_key = n_found_key | cell_key[i];
            end
        end

        n_status = ST_OK;
        n_count  = r_count;
        for (int i = 0; i < DEPTH; i++) begin
            cell_act[i] = ACT_HOLD;
        end
        unique case (r_type)
            REQ_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (lt_vec[i]) begin
                            cell_act[i] = ACT_HOLD;
                        end else if (i == 0) begin
                            cell_act[i] = ACT_LOAD;
                        end else if (lt_vec[(i == 0) ? 0 : i - 1]) begin
                            cell_act[i] = ACT_LOAD;
                        end else begin
                            cell_act[i] = ACT_FROM_PREV;
                        end
                    end
                end
            end
            REQ_REMOVE_ID: begin
                if (id_hit) begin
                    n_count = r_count - CNT_W'(1);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (hit_before[i] || eq_vec[i]) begin
                            cell_act[i] = ACT_FROM_NEXT;
                        end
                    end
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            REQ_REMOVE_POS: begin
                if (pos_hit) begin
                    n_count = r_count - CNT_W'(1);
                    for (int i = 0; i < DEPTH; i++) begin
                        if (past_pos[i]) begin
                            cell_act[i] = ACT_FROM_NEXT;
                        end
                    end
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            REQ_READ: begin
                if (!pos_hit) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase

        if (!do_exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                cell_act[i] = ACT_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && !do_exec) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_type  <= t_req_type'(i_req.req_type);
                        r_id    <= i_req.entry_id;
                        r_key   <= i_req.entry_key;
                        r_pos   <= i_req.position;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (can_out) begin
                        r_count     <= n_count;
                        r_out_valid <= 1'b1;
                        r_status    <= n_status;
                        r_found_id  <= n_found_id;
                        r_found_key <= n_found_key;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.fill_count = FILL_W'(r_count);
    assign o_rsp.found_id   = r_found_id;
    assign o_rsp.found_key  = r_found_key;

`ifndef SYNTHESIS
    // The list never holds more entries than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above list depth");

    // Keys stay sorted, so the "stored key is smaller" flags form a run from the head.
    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> ((lt_vec & (lt_vec + DEPTH'(1))) == '0))
        else $error("slot order broken");

    // A response word appears only out of the execute step.
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("response without an executed request");

    // A full status is reported only when every slot is occupied.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_FULL)) |-> (r_count == CNT_W'(DEPTH)))
        else $error("full status on a list with free slots");
`endif

endmodule

// ===== rtl/sle_cell.sv =====
// One slot of the sorted list: holds an entry, compares it, and shifts with its neighbors.
module sle_cell import sle_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_cap,
    input  logic                     i_occ,
    input  logic signed [DATA_W-1:0] i_cmp_id,
    input  logic signed [DATA_W-1:0] i_cmp_key,
    input  t_cell_act                i_act,
    input  logic signed [DATA_W-1:0] i_new_id,
    input  logic signed [DATA_W-1:0] i_new_key,
    input  logic signed [DATA_W-1:0] i_prev_id,
    input  logic signed [DATA_W-1:0] i_prev_key,
    input  logic signed [DATA_W-1:0] i_next_id,
    input  logic signed [DATA_W-1:0] i_next_key,
    output logic signed [DATA_W-1:0] o_id,
    output logic signed [DATA_W-1:0] o_key,
    output t_cell_flags              o_flags
);

    logic signed [DATA_W-1:0] r_id;
    logic signed [DATA_W-1:0] r_key;
    t_cell_flags              r_flags;
    t_cell_flags              n_flags;

    always_comb begin
        n_flags.lt = i_occ && (r_key < i_cmp_key);
        n_flags.eq = i_occ && (r_id == i_cmp_id);
    end

    always_ff @(posedge i_clk) begin
        if (i_cap) begin
            r_flags <= n_flags;
        end
        case (i_act)
            ACT_LOAD: begin
                r_id  <= i_new_id;
                r_key <= i_new_key;
            end
            ACT_FROM_PREV: begin
                r_id  <= i_prev_id;
                r_key <= i_prev_key;
            end
            ACT_FROM_NEXT: begin
                r_id  <= i_next_id;
                r_key <= i_next_key;
            end
            default: begin
            end
        endcase
    end

    assign o_id    = r_id;
    assign o_key   = r_key;
    assign o_flags = r_flags;

endmodule

// ===== test/sorted_list_engine_test.sv =====
// Self-checking testbench for the sorted list engine: directed table, then random traffic.
`timescale 1ns / 1ps

module sorted_list_engine_test;
    import sle_pkg::*;

    localparam int RANDOM_ITEMS   = 800;
    localparam int HOLD_AFTER     = 200;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 5;

    typedef struct packed {
        t_req_type                kind;
        logic signed [DATA_W-1:0] id;
        logic signed [DATA_W-1:0] key;
        logic [POS_W-1:0]         pos;
    } t_list_request;

    typedef struct packed {
        t_status                  status;
        logic [FILL_W-1:0]        fill;
        logic signed [DATA_W-1:0] id;
        logic signed [DATA_W-1:0] key;
    } t_list_response;

    typedef struct {
        t_list_request     req;
        bit                typed;
        t_status           status;
        logic [FILL_W-1:0] fill;
    } t_directed_row;

    logic clk = 1'b0;
    logic rst_n;

    sle_req_if req_bus ();
    sle_rsp_if rsp_bus ();

    sorted_list_engine u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    // Shadow copy of the list, head at index 0.
    int list_keys[$];
    int list_ids[$];

    t_list_response awaited_rsp[$];
    t_directed_row  directed_rows[$];
    int             mismatch_count = 0;
    int             sent_count = 0;
    int             idle_cycles = 0;

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic t_list_response apply_to_list(input t_list_request r);
        t_list_response rsp;
        int             new_key;
        int             at;
        int             hit;
        rsp = '0;
        rsp.status = ST_OK;
        new_key = r.key;
        case (r.kind)
            REQ_INSERT: begin
                if (list_keys.size() >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    // Equal keys stop the scan, so the newest entry lands first among them.
                    at = 0;
                    while (at < list_keys.size() && list_keys[at] < new_key) at++;
                    list_keys.insert(at, new_key);
                    list_ids.insert(at, int'(r.id));
                end
            end
            REQ_REMOVE_ID: begin
                hit = -1;
                for (int i = 0; i < list_ids.size(); i++) begin
                    if (hit < 0 && list_ids[i] == int'(r.id)) hit = i;
                end
                if (hit >= 0) begin
                    rsp.id  = list_ids[hit];
                    rsp.key = list_keys[hit];
                    list_ids.delete(hit);
                    list_keys.delete(hit);
                end else begin
                    rsp.status = ST_NOT_FOUND;
                end
            end
            default: begin
                if (int'(r.pos) < list_keys.size()) begin
                    rsp.id  = list_ids[r.pos];
                    rsp.key = list_keys[r.pos];
                    if (r.kind == REQ_REMOVE_POS) begin
                        list_ids.delete(r.pos);
                        list_keys.delete(r.pos);
                    end
                end else begin
                    rsp.status = ST_NOT_FOUND;
                end
            end
        endcase
        rsp.fill = FILL_W'(list_keys.size());
        return rsp;
    endfunction

    // Mostly short gaps, a few long ones, and whole stretches with none.
    function automatic int idle_gap(input int n);
        int roll;
        roll = $urandom_range(0, 99);
        if ((n / 50) % 5 == 0) return 0;
        if (roll < 8) return $urandom_range(10, 40);
        if (roll < 55) return 0;
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [DATA_W-1:0] pick_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return $urandom_range(0, 15);
        if (roll < 75) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            default: return 32'h0;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return $urandom_range(0, 8) - 4;
        if (roll < 80) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h7fff_fffe;
            default: return 32'h8000_0001;
        endcase
    endfunction

    function automatic t_list_request random_request(input int n);
        t_list_request r;
        int            fill;
        int            insert_pct;
        int            roll;
        r = '0;
        fill = list_keys.size();
        // Alternate between filling and draining so both ends of the list get exercised.
        insert_pct = ((n / 120) % 2 == 0) ? 70 : 25;
        if ($urandom_range(0, 99) < 10) begin
            r.kind = t_req_type'($urandom_range(0, 3));
            r.id   = $urandom;
            r.key  = $urandom;
            r.pos  = POS_W'($urandom_range(0, 255));
            return r;
        end
        r.key = pick_key();
        r.id  = pick_id();
        roll = $urandom_range(0, 99);
        if (roll < insert_pct) begin
            r.kind = REQ_INSERT;
            r.pos  = POS_W'($urandom_range(0, 255));
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 40) r.kind = REQ_REMOVE_ID;
            else if (roll < 70) r.kind = REQ_REMOVE_POS;
            else r.kind = REQ_READ;
            if (fill > 0 && $urandom_range(0, 99) < 85) begin
                r.pos = POS_W'($urandom_range(0, fill - 1));
                if (r.kind == REQ_REMOVE_ID) r.id = list_ids[$urandom_range(0, fill - 1)];
            end else begin
                r.pos = POS_W'($urandom_range(fill, 255));
            end
        end
        return r;
    endfunction

    task automatic add_row(input t_req_type kind, input logic [DATA_W-1:0] id,
                           input logic [DATA_W-1:0] key, input logic [POS_W-1:0] pos,
                           input bit typed, input t_status status,
                           input logic [FILL_W-1:0] fill);
        t_directed_row row;
        row.req.kind = kind;
        row.req.id   = id;
        row.req.key  = key;
        row.req.pos  = pos;
        row.typed    = typed;
        row.status   = status;
        row.fill     = fill;
        directed_rows.push_back(row);
    endtask

    // Offers one request word and, once it is taken, records what must come back.
    task automatic send_request(input t_list_request r, input bit typed,
                                input t_status status, input logic [FILL_W-1:0] fill);
        int             gap;
        t_list_response want;
        gap = idle_gap(sent_count);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= r.kind;
        req_bus.entry_id  <= r.id;
        req_bus.entry_key <= r.key;
        req_bus.position  <= r.pos;
        do @(posedge clk); while (!req_bus.ready);
        want = apply_to_list(r);
        if (typed) begin
            want        = '0;
            want.status = status;
            want.fill   = fill;
        end
        awaited_rsp.push_back(want);
        sent_count++;
    endtask

    initial begin
        rst_n             <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.req_type  <= REQ_INSERT;
        req_bus.entry_id  <= '0;
        req_bus.entry_key <= '0;
        req_bus.position  <= '0;

        //      kind            id             key            pos  typed status        fill
        add_row(REQ_READ,       32'h0,         32'h0,         0,   1,    ST_NOT_FOUND, 0);
        add_row(REQ_REMOVE_ID,  32'h0,         32'h0,         0,   1,    ST_NOT_FOUND, 0);
        add_row(REQ_REMOVE_POS, 32'h0,         32'h0,         0,   1,    ST_NOT_FOUND, 0);
        add_row(REQ_INSERT,     32'h7fff_ffff, 32'h7fff_ffff, 0,   1,    ST_OK,        1);
        add_row(REQ_INSERT,     32'h8000_0000, 32'h8000_0000, 255, 1,    ST_OK,        2);
        add_row(REQ_INSERT,     32'h1,         32'h0,         0,   1,    ST_OK,        3);
        add_row(REQ_INSERT,     32'h2,         32'h0,         0,   1,    ST_OK,        4);
        add_row(REQ_INSERT,     32'h3,         32'hffff_ffff, 0,   1,    ST_OK,        5);
        add_row(REQ_INSERT,     32'h4,         32'h1,         0,   1,    ST_OK,        6);
        add_row(REQ_INSERT,     32'h1,         32'h5,         0,   1,    ST_OK,        7);
        add_row(REQ_INSERT,     32'hffff_ffff, 32'h8000_0001, 0,   1,    ST_OK,        8);
        add_row(REQ_INSERT,     32'h0,         32'h7fff_fffe, 0,   1,    ST_OK,        9);
        add_row(REQ_INSERT,     32'h5,         32'h0,         0,   1,    ST_OK,        10);
        add_row(REQ_INSERT,     32'h6,         32'hffff_ff9c, 0,   1,    ST_OK,        11);
        add_row(REQ_INSERT,     32'h7,         32'h64,        0,   1,    ST_OK,        12);
        add_row(REQ_INSERT,     32'h8,         32'h7fff_ffff, 0,   1,    ST_OK,        13);
        add_row(REQ_INSERT,     32'h9,         32'h8000_0000, 0,   1,    ST_OK,        14);
        add_row(REQ_INSERT,     32'ha,         32'h3,         0,   1,    ST_OK,        15);
        add_row(REQ_INSERT,     32'hb,         32'hffff_fffd, 0,   1,    ST_OK,        16);
        add_row(REQ_INSERT,     32'hc,         32'h0,         0,   1,    ST_FULL,      16);
        add_row(REQ_READ,       32'h0,         32'h0,         255, 1,    ST_NOT_FOUND, 16);
        add_row(REQ_READ,       32'h0,         32'h0,         15,  0,    ST_OK,        0);
        add_row(REQ_REMOVE_ID,  32'h1,         32'h0,         0,   0,    ST_OK,        0);
        add_row(REQ_REMOVE_POS, 32'h0,         32'h0,         0,   0,    ST_OK,        0);
        add_row(REQ_REMOVE_POS, 32'h0,         32'h0,         14,  1,    ST_NOT_FOUND, 14);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed,
                         directed_rows[i].status, directed_rows[i].fill);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_request(random_request(n), 1'b0, ST_OK, '0);
        req_bus.valid <= 1'b0;

        while (awaited_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("sorted_list_engine test passed");
        end else begin
            $display("sorted_list_engine test failed");
        end
        $finish;
    end

    // Response side: random back-pressure plus one long hold-off that fills the block.
    initial begin
        int  gap;
        int  taken;
        bit  held;
        taken = 0;
        held  = 1'b0;
        rsp_bus.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            gap = idle_gap(taken);
            if (!held && taken >= HOLD_AFTER) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge clk); while (!rsp_bus.valid);
            taken++;
        end
    end

    always @(posedge clk) begin
        t_list_response want;
        if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (awaited_rsp.size() == 0) begin
                report_mismatch("response word arrived with no request outstanding");
            end else begin
                want = awaited_rsp.pop_front();
                if (rsp_bus.status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              rsp_bus.status, want.status));
                if (rsp_bus.fill_count !== want.fill)
                    report_mismatch($sformatf("fill_count got %0d expected %0d",
                                              rsp_bus.fill_count, want.fill));
                if (rsp_bus.found_id !== want.id)
                    report_mismatch($sformatf("found_id got %h expected %h",
                                              rsp_bus.found_id, want.id));
                if (rsp_bus.found_key !== want.key)
                    report_mismatch($sformatf("found_key got %h expected %h",
                                              rsp_bus.found_key, want.key));
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n !== 1'b1 || (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_list_engine test failed");
            $finish;
        end
    end

endmodule

// ===== files.f =====
rtl/sle_pkg.sv
rtl/sle_if.sv
rtl/sle_cell.sv
rtl/sorted_list_engine.sv
test/sorted_list_engine_test.sv
